FILE: hw/rtl/midpoint_ellipse_rasterizer_top_macros.svh
// assertion macros for the checker file
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mer_pkg.sv
package mer_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int PT_W        = RADIUS_BITS + 1;
    localparam int SQ_W        = 2 * RADIUS_BITS;
    localparam int MUL_W       = 2 * PT_W + 2;
    localparam int DEC_W       = 48;
    localparam int PIX_W       = 14;
    localparam int COLOR_W     = 24;
    localparam int IN_FIELDS_W = 2 * COORD_BITS + 2 * RADIUS_BITS;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * PIX_W + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // action codes carried on tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // register index of the pixel color, taken from paddr[2]
    localparam logic REG_COLOR = 1'b0;

    // classified input word
    typedef struct packed {
        logic                   is_step;
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius_x;
        logic [RADIUS_BITS-1:0] radius_y;
    } t_item;

    // one point to be mirrored into four pixels
    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [PT_W-1:0]       point_x;
        logic [PT_W-1:0]       point_y;
        logic                  fin;
    } t_job;

endpackage

FILE: hw/rtl/mer_front.sv
module mer_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // center_x, center_y, radius_x, radius_y, zero pad
    input  logic [mer_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // action
    input  logic                          s_axis_tuser,
    output logic                          o_item_valid,
    output mer_pkg::t_item                o_item,
    input  logic                          i_pop
);

    localparam int CB = mer_pkg::COORD_BITS;
    localparam int RB = mer_pkg::RADIUS_BITS;

    mer_pkg::t_item r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           push;
    mer_pkg::t_item in_item;

    // unpack and classify the incoming word
    always_comb begin
        in_item.is_step  = (s_axis_tuser == mer_pkg::ACT_STEP);
        in_item.center_x = s_axis_tdata[CB-1:0];
        in_item.center_y = s_axis_tdata[2*CB-1:CB];
        in_item.radius_x = s_axis_tdata[2*CB+RB-1:2*CB];
        in_item.radius_y = s_axis_tdata[2*CB+2*RB-1:2*CB+RB];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_cnt != 2'd0);
    assign o_item        = r_q[r_rd];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            if (push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= in_item;
    end

endmodule

FILE: hw/rtl/mer_core.sv
module mer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  mer_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_job_valid,
    output mer_pkg::t_job  o_job,
    input  logic           i_job_ready
);

    localparam int PT_W  = mer_pkg::PT_W;
    localparam int SQ_W  = mer_pkg::SQ_W;
    localparam int MUL_W = mer_pkg::MUL_W;
    localparam int DEC_W = mer_pkg::DEC_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ST_A2  = 4'd1;
    localparam logic [3:0] S_ST_B2  = 4'd2;
    localparam logic [3:0] S_ST_AB  = 4'd3;
    localparam logic [3:0] S_ST_DEC = 4'd4;
    localparam logic [3:0] S_AD_P1  = 4'd5;
    localparam logic [3:0] S_AD_CMP = 4'd6;
    localparam logic [3:0] S_R2_BT  = 4'd7;
    localparam logic [3:0] S_R2_YY  = 4'd8;
    localparam logic [3:0] S_R2_AY  = 4'd9;
    localparam logic [3:0] S_R2_AB  = 4'd10;
    localparam logic [3:0] S_R2_END = 4'd11;
    localparam logic [3:0] S_AD_UPD = 4'd12;

    logic [3:0]                     r_state;
    logic [3:0]                     n_state;
    logic                           r_active;
    logic                           r_reg2;
    logic                           r_job_valid;
    mer_pkg::t_job                  r_job;
    logic [mer_pkg::COORD_BITS-1:0] r_cx;
    logic [mer_pkg::COORD_BITS-1:0] r_cy;
    logic [mer_pkg::RADIUS_BITS-1:0] r_rx;
    logic [mer_pkg::RADIUS_BITS-1:0] r_ry;
    logic [SQ_W-1:0]                r_a2;
    logic [SQ_W-1:0]                r_b2;
    logic [PT_W-1:0]                r_px;
    logic [PT_W-1:0]                r_py;
    logic [DEC_W-1:0]               r_dec;
    logic [DEC_W-1:0]               r_p0;
    logic [DEC_W-1:0]               r_p1;
    logic [DEC_W-1:0]               r_mul;

    logic [MUL_W-1:0]   op_a;
    logic [MUL_W-1:0]   op_b;
    logic [2*MUL_W-1:0] prod;
    logic [PT_W-1:0]    ym;
    logic [DEC_W-1:0]   a2w;
    logic [DEC_W-1:0]   b2w;
    logic [DEC_W-1:0]   r1_upd;
    logic [DEC_W-1:0]   r2_upd;
    logic               dec_pos;
    logic               upd_go;
    logic               to_reg2;

    assign a2w     = DEC_W'(r_a2);
    assign b2w     = DEC_W'(r_b2);
    assign ym      = (r_py == '0) ? PT_W'(1) : r_py - PT_W'(1);
    assign dec_pos = !r_dec[DEC_W-1] && (r_dec != '0);
    assign r1_upd  = (r_p0 << 3) + (b2w << 3) + (b2w << 2);
    assign r2_upd  = (a2w << 3) + (a2w << 2) - (r_p1 << 3);
    assign upd_go  = !r_job_valid || i_job_ready;
    assign to_reg2 = !r_reg2 && (r_p0 > r_mul);
    assign o_pop   = (r_state == S_IDLE) && i_item_valid;
    assign o_job_valid = r_job_valid;
    assign o_job   = r_job;

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_IDLE: begin
                op_a = MUL_W'(r_b2);
                op_b = MUL_W'(r_px);
            end
            S_ST_A2: begin
                op_a = MUL_W'(r_rx);
                op_b = MUL_W'(r_rx);
            end
            S_ST_B2: begin
                op_a = MUL_W'(r_ry);
                op_b = MUL_W'(r_ry);
            end
            S_ST_AB: begin
                op_a = MUL_W'(r_a2);
                op_b = MUL_W'(r_ry);
            end
            S_AD_P1: begin
                op_a = MUL_W'(r_a2);
                op_b = MUL_W'(r_py);
            end
            S_AD_CMP: begin
                op_a = MUL_W'({r_px, 1'b1});
                op_b = MUL_W'({r_px, 1'b1});
            end
            S_R2_BT: begin
                op_a = r_mul[MUL_W-1:0];
                op_b = MUL_W'(r_b2);
            end
            S_R2_YY: begin
                op_a = MUL_W'(ym);
                op_b = MUL_W'(ym);
            end
            S_R2_AY: begin
                op_a = r_mul[MUL_W-1:0];
                op_b = MUL_W'(r_a2);
            end
            S_R2_AB: begin
                op_a = MUL_W'(r_a2);
                op_b = MUL_W'(r_b2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (!i_item.is_step) n_state = S_ST_A2;
                    else if (r_active) n_state = S_AD_P1;
                end
            end
            S_ST_A2:  n_state = S_ST_B2;
            S_ST_B2:  n_state = S_ST_AB;
            S_ST_AB:  n_state = S_ST_DEC;
            S_ST_DEC: n_state = S_IDLE;
            S_AD_P1:  n_state = S_AD_CMP;
            S_AD_CMP: n_state = to_reg2 ? S_R2_BT : S_AD_UPD;
            S_R2_BT:  n_state = S_R2_YY;
            S_R2_YY:  n_state = S_R2_AY;
            S_R2_AY:  n_state = S_R2_AB;
            S_R2_AB:  n_state = S_R2_END;
            S_R2_END: n_state = S_AD_UPD;
            S_AD_UPD: if (upd_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_reg2      <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_job_valid && i_job_ready) r_job_valid <= 1'b0;
            if (r_state == S_IDLE && i_item_valid && !i_item.is_step) begin
                r_reg2 <= 1'b0;
            end
            if (r_state == S_ST_DEC) r_active <= 1'b1;
            if (r_state == S_R2_END) r_reg2 <= 1'b1;
            if (r_state == S_AD_UPD && upd_go) begin
                r_job_valid <= 1'b1;
                if (r_py == '0 && (r_reg2 || !r_dec[DEC_W-1])) r_active <= 1'b0;
            end
        end
    end

    // geometry, decision and product registers
    always_ff @(posedge i_clk) begin
        r_mul <= DEC_W'(prod);
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && !i_item.is_step) begin
                    r_cx <= i_item.center_x;
                    r_cy <= i_item.center_y;
                    r_rx <= i_item.radius_x;
                    r_ry <= i_item.radius_y;
                    r_px <= '0;
                    r_py <= PT_W'(i_item.radius_y);
                end
            end
            S_ST_B2:  r_a2 <= r_mul[SQ_W-1:0];
            S_ST_AB:  r_b2 <= r_mul[SQ_W-1:0];
            S_ST_DEC: r_dec <= (b2w << 2) - (r_mul << 2) + a2w;
            S_AD_P1:  r_p0 <= r_mul;
            S_AD_CMP: r_p1 <= r_mul;
            S_R2_YY:  r_dec <= r_mul;
            S_R2_AB:  r_dec <= r_dec + (r_mul << 2);
            S_R2_END: r_dec <= r_dec - (r_mul << 2);
            S_AD_UPD: begin
                if (upd_go) begin
                    r_job.center_x <= r_cx;
                    r_job.center_y <= r_cy;
                    r_job.point_x  <= r_px;
                    r_job.point_y  <= r_py;
                    r_job.fin      <= 1'b0;
                    if (r_reg2) begin
                        // region two: y steps down every point
                        if (r_py == '0) begin
                            r_job.fin <= 1'b1;
                        end else begin
                            if (dec_pos) begin
                                r_dec <= r_dec + r2_upd;
                            end else begin
                                r_dec <= r_dec + r2_upd + (r_p0 << 3) + (b2w << 3);
                                r_px  <= r_px + PT_W'(1);
                            end
                            r_py <= r_py - PT_W'(1);
                        end
                    end else begin
                        // region one: x steps up every point
                        if (r_dec[DEC_W-1]) begin
                            r_dec <= r_dec + r1_upd;
                            r_px  <= r_px + PT_W'(1);
                        end else if (r_py == '0) begin
                            r_job.fin <= 1'b1;
                        end else begin
                            r_dec <= r_dec + r1_upd - (r_p1 << 3) + (a2w << 3);
                            r_px  <= r_px + PT_W'(1);
                            r_py  <= r_py - PT_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/mer_emit.sv
module mer_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  mer_pkg::t_job                  i_job,
    output logic                           o_job_ready,
    input  logic [mer_pkg::COLOR_W-1:0]    i_color,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x, pixel_y, color, zero pad
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int PIX_W = mer_pkg::PIX_W;
    localparam int PAD_W = mer_pkg::OUT_TDATA_W - mer_pkg::OUT_FIELDS_W;

    mer_pkg::t_job                 r_job;
    logic                          r_busy;
    logic [1:0]                    r_idx;
    logic                          r_ov;
    logic [PIX_W-1:0]              r_pix_x;
    logic [PIX_W-1:0]              r_pix_y;
    logic [mer_pkg::COLOR_W-1:0]   r_color;
    logic                          r_last;
    logic                          adv;
    logic                          take;
    logic [PIX_W-1:0]              x_pos;
    logic [PIX_W-1:0]              x_neg;
    logic [PIX_W-1:0]              y_pos;
    logic [PIX_W-1:0]              y_neg;

    assign adv         = !r_ov || m_axis_tready;
    assign o_job_ready = !r_busy || (adv && r_idx == 2'd3);
    assign take        = i_job_valid && o_job_ready;

    // mirrored coordinates around the center
    assign x_pos = PIX_W'(r_job.center_x) + PIX_W'(r_job.point_x);
    assign x_neg = PIX_W'(r_job.center_x) - PIX_W'(r_job.point_x);
    assign y_pos = PIX_W'(r_job.center_y) + PIX_W'(r_job.point_y);
    assign y_neg = PIX_W'(r_job.center_y) - PIX_W'(r_job.point_y);

    // quadrant counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= r_busy;
                if (r_busy) begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_busy <= 1'b0;
                end
            end
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (take) r_job <= i_job;
        if (adv && r_busy) begin
            r_color <= i_color;
            r_last  <= 1'b0;
            unique case (r_idx)
                2'd0: begin
                    r_pix_x <= x_pos;
                    r_pix_y <= y_pos;
                end
                2'd1: begin
                    r_pix_x <= x_neg;
                    r_pix_y <= y_pos;
                end
                2'd2: begin
                    r_pix_x <= x_pos;
                    r_pix_y <= y_neg;
                end
                2'd3: begin
                    r_pix_x <= x_neg;
                    r_pix_y <= y_neg;
                    r_last  <= r_job.fin;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {PAD_W'(0), r_color, r_pix_y, r_pix_x};
    assign m_axis_tlast  = r_last;

endmodule

FILE: hw/rtl/midpoint_ellipse_rasterizer_top.sv
// Axis-aligned midpoint ellipse rasterizer. A word with tuser = 0 loads the
// center and both radii and restarts the ellipse at (0, radius_y); it produces
// no output and runs the setup states of the sequencer. A word with tuser = 1
// produces the four mirrored pixels of the current point, in the order
// (+x,+y), (-x,+y), (+x,-y), (-x,-y), and then moves to the next point; tlast
// marks the fourth pixel of the final point, and step words after that produce
// nothing. A step runs two products on the shared 26x26 multiplier, a region
// compare and the decision update; the single step that crosses into region
// two also builds its starting decision in states S_R2_BT to S_R2_END. Pixels
// leave one per cycle from an output register while tready is high, and a
// 2-deep input queue lets the sender run ahead of the sequencer. The pixel
// color comes from the register at APB address 0.
module midpoint_ellipse_rasterizer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // center_x, center_y, radius_x, radius_y, zero pad
    input  logic [mer_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_x, pixel_y, color, zero pad
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mer_pkg::APB_AW-1:0]      paddr,
    input  logic [mer_pkg::APB_DW-1:0]      pwdata,
    output logic [mer_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    logic [mer_pkg::COLOR_W-1:0] r_color;
    logic                        item_valid;
    mer_pkg::t_item              item;
    logic                        pop;
    logic                        job_valid;
    mer_pkg::t_job               job;
    logic                        job_ready;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == mer_pkg::REG_COLOR) begin
            r_color <= pwdata[mer_pkg::COLOR_W-1:0];
        end
    end
    assign prdata = (paddr[2] == mer_pkg::REG_COLOR) ? mer_pkg::APB_DW'(r_color) : '0;

    mer_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_pop         (pop)
    );

    mer_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_ready  (job_ready)
    );

    mer_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .i_color       (r_color),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: hw/rtl/mer_checker.sv
`include "midpoint_ellipse_rasterizer_top_macros.svh"

module mer_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [mer_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [mer_pkg::APB_AW-1:0]      paddr,
    input logic [mer_pkg::APB_DW-1:0]      pwdata,
    input logic [mer_pkg::APB_DW-1:0]      prdata,
    input logic                            pready
);

    // a stalled output word holds
    `MER_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // nothing comes out in the first cycle after reset
    `MER_ASSERT_NOW(a_quiet_after_reset, !$past(i_rst_n), !m_axis_tvalid, "output valid right after reset")

    // a color write reads back on the next cycle
    `MER_ASSERT_NEXT(a_color_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || prdata[mer_pkg::COLOR_W-1:0] == $past(pwdata[mer_pkg::COLOR_W-1:0]), "color register readback mismatch")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_checker (.*);

FILE: tb/tb.sv
module tb;
    import mer_pkg::*;

    // which expectation a stimulus word carries
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_DOT
    } chk_t;

    // output ready patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_t;

    // one input word plus its hand-typed expectation, if any
    typedef struct packed {
        logic                   act;
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        chk_t                   chk;
        logic [PIX_W-1:0]       ex;
        logic [PIX_W-1:0]       ey;
        logic [COLOR_W-1:0]     ecol;
    } ellipse_word_t;

    // one plotted pixel
    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    localparam int NUM_DIR      = 26;
    localparam int COLOR_ROW    = 4;
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 160;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_WORDS  = 100;
    localparam logic [APB_AW-1:0] COLOR_ADDR = {REG_COLOR, 2'b00};

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_AW-1:0]       paddr         = '0;
    logic [APB_DW-1:0]       pwdata        = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // word currently offered on the input, with its expectation kind
    ellipse_word_t in_flight = '0;

    // predictor copy of the rasterizer state
    logic [COORD_BITS-1:0]  ell_cx    = '0;
    logic [COORD_BITS-1:0]  ell_cy    = '0;
    logic [RADIUS_BITS-1:0] ell_rx    = '0;
    logic [RADIUS_BITS-1:0] ell_ry    = '0;
    logic [PT_W-1:0]        ell_px    = '0;
    logic [PT_W-1:0]        ell_py    = '0;
    logic [DEC_W-1:0]       ell_dec   = '0;
    bit                     ell_r2    = 1'b0;
    bit                     ell_busy  = 1'b0;
    logic [COLOR_W-1:0]     pix_color = '0;

    pixel_t pending_pixels [$];
    int     pixel_errors = 0;
    int     reg_errors   = 0;
    int     pixels_seen  = 0;
    int     quiet_cycles = 0;
    int     burst_left   = 0;

    // directed words: edges of the fields, idle and busy restarts, both regions
    ellipse_word_t directed_words [NUM_DIR] = '{
        // advance while idle after reset
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_START, 12'd5,    12'd7,    11'd0,    11'd0,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        // zero radii: one point, reset color
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_DOT,  14'd5,    14'd7,    24'h0},
        // advance after the final point
        '{ACT_STEP,  12'hFFF,  12'hFFF,  11'h7FF,  11'h7FF,  CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_START, 12'hFFF,  12'hFFF,  11'd0,    11'd0,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_DOT,  14'd4095, 14'd4095,
          24'hFFFFFF},
        // zero vertical radius ends in region one
        '{ACT_START, 12'hFFF,  12'd0,    11'd3,    11'd0,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_DOT,  14'd4095, 14'd0,
          24'hFFFFFF},
        // negative pixel coordinates at the origin
        '{ACT_START, 12'd0,    12'd0,    11'd0,    11'd1,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_START, 12'd100,  12'd200,  11'd5,    11'd3,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        // restart while busy, widest radii
        '{ACT_START, 12'd0,    12'hFFF,  11'h7FF,  11'h7FF,  CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        // small ellipse through region two to its end
        '{ACT_START, 12'd2048, 12'd2048, 11'd3,    11'd2,    CHK_NONE, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0},
        '{ACT_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PRED, 14'd0,    14'd0,    24'h0}
    };

    midpoint_ellipse_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predicted pixels of one word, decision kept at four times its real value
    task automatic rasterize_word(input ellipse_word_t w, output int n, output pixel_t quad [4]);
        logic [63:0] a2, b2, x, y, t, upd, acc;
        logic [63:0] xp, xm, yp, ym;
        bit          fin;
        n   = 0;
        fin = 1'b0;
        if (w.act == ACT_START) begin
            ell_cx   = w.cx;
            ell_cy   = w.cy;
            ell_rx   = w.rx;
            ell_ry   = w.ry;
            a2       = 64'(w.rx);
            a2       = a2 * a2;
            b2       = 64'(w.ry);
            y        = b2;
            b2       = b2 * b2;
            ell_px   = '0;
            ell_py   = PT_W'(w.ry);
            acc      = 4 * b2 - 4 * a2 * y + a2;
            ell_dec  = acc[DEC_W-1:0];
            ell_r2   = 1'b0;
            ell_busy = 1'b1;
            return;
        end
        if (!ell_busy)
            return;

        a2 = 64'(ell_rx);
        a2 = a2 * a2;
        b2 = 64'(ell_ry);
        b2 = b2 * b2;
        x  = 64'(ell_px);
        y  = 64'(ell_py);

        // crossing into region two rebuilds the decision
        if (!ell_r2 && !(b2 * x <= a2 * y)) begin
            t       = 2 * x + 1;
            upd     = y - 1;
            acc     = b2 * t * t + 4 * a2 * upd * upd - 4 * a2 * b2;
            ell_dec = acc[DEC_W-1:0];
            ell_r2  = 1'b1;
        end

        if (ell_r2) begin
            if (y == 0) begin
                fin = 1'b1;
            end else begin
                upd = 12 * a2 - 8 * a2 * y;
                if (!ell_dec[DEC_W-1] && ell_dec != '0) begin
                    acc = 64'(ell_dec) + upd;
                end else begin
                    acc    = 64'(ell_dec) + upd + 8 * b2 * (x + 1);
                    t      = x + 1;
                    ell_px = t[PT_W-1:0];
                end
                ell_dec = acc[DEC_W-1:0];
                t       = y - 1;
                ell_py  = t[PT_W-1:0];
            end
        end else begin
            upd = 4 * b2 * (2 * x + 3);
            if (ell_dec[DEC_W-1]) begin
                acc     = 64'(ell_dec) + upd;
                ell_dec = acc[DEC_W-1:0];
                t       = x + 1;
                ell_px  = t[PT_W-1:0];
            end else if (y == 0) begin
                fin = 1'b1;
            end else begin
                acc     = 64'(ell_dec) + upd - 8 * a2 * (y - 1);
                ell_dec = acc[DEC_W-1:0];
                t       = x + 1;
                ell_px  = t[PT_W-1:0];
                t       = y - 1;
                ell_py  = t[PT_W-1:0];
            end
        end
        if (fin)
            ell_busy = 1'b0;

        // four mirrored pixels of the point before the move
        xp = 64'(ell_cx) + x;
        xm = 64'(ell_cx) - x;
        yp = 64'(ell_cy) + y;
        ym = 64'(ell_cy) - y;
        quad[0] = '{xp[PIX_W-1:0], yp[PIX_W-1:0], pix_color, 1'b0};
        quad[1] = '{xm[PIX_W-1:0], yp[PIX_W-1:0], pix_color, 1'b0};
        quad[2] = '{xp[PIX_W-1:0], ym[PIX_W-1:0], pix_color, 1'b0};
        quad[3] = '{xm[PIX_W-1:0], ym[PIX_W-1:0], pix_color, fin};
        n = 4;
    endtask

    // scoreboard: check pixels leaving, predict pixels for words entering
    always @(posedge i_clk) begin : scoreboard
        pixel_t quad [4];
        pixel_t got;
        pixel_t want;
        int     n;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.px    = m_axis_tdata[PIX_W-1:0];
                got.py    = m_axis_tdata[2*PIX_W-1:PIX_W];
                got.color = m_axis_tdata[2*PIX_W+COLOR_W-1:2*PIX_W];
                got.last  = m_axis_tlast;
                pixels_seen++;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected pixel word x=%0d y=%0d",
                           $signed(got.px), $signed(got.py));
                    pixel_errors++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.px !== want.px) begin
                        $error("pixel_x: expected %0d, actual %0d",
                               $signed(want.px), $signed(got.px));
                        pixel_errors++;
                    end
                    if (got.py !== want.py) begin
                        $error("pixel_y: expected %0d, actual %0d",
                               $signed(want.py), $signed(got.py));
                        pixel_errors++;
                    end
                    if (got.color !== want.color) begin
                        $error("color: expected %h, actual %h", want.color, got.color);
                        pixel_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, got.last);
                        pixel_errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rasterize_word(in_flight, n, quad);
                case (in_flight.chk)
                    CHK_NONE: begin
                    end
                    CHK_DOT: begin
                        for (int k = 0; k < 4; k++)
                            pending_pixels.push_back('{in_flight.ex, in_flight.ey,
                                                       in_flight.ecol, k == 3});
                    end
                    default: begin
                        for (int k = 0; k < n; k++)
                            pending_pixels.push_back(quad[k]);
                    end
                endcase
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // output backpressure, with one long hold once traffic is flowing
    initial begin : receiver
        stall_t mode;
        int     span;
        int     phase;
        bit     held;
        held  = 1'b0;
        phase = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && pixels_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = stall_t'($urandom_range(0, 2));
            span = $urandom_range(16, 96);
            repeat (span) begin
                case (mode)
                    STALL_NONE:   m_axis_tready <= 1'b1;
                    STALL_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:      m_axis_tready <= (phase % 5) < 3;
                endcase
                phase++;
                @(posedge i_clk);
            end
        end
    end

    // sender bursts: random length, random gaps, some back to back
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // offer one word and hold it until taken
    task automatic send_word(input ellipse_word_t w);
        logic [IN_TDATA_W-1:0] packed_word;
        packed_word = '0;
        packed_word[IN_FIELDS_W-1:0] = {w.ry, w.rx, w.cy, w.cx};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.act;
        s_axis_tdata  <= packed_word;
        in_flight     <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // let every predicted pixel out, then give queued non-drawing words time
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write the color register, junk in the unused bits, and read it back
    task automatic program_color(input logic [COLOR_W-1:0] c);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_ADDR;
        pwdata  <= {8'($urandom), c};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pix_color = c;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {8'h00, c}) begin
            $error("pixel_color readback: expected %h, actual %h", {8'h00, c}, prdata);
            reg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly whole ellipses with small radii, some cut short, some noise
    task automatic run_random(input int target);
        ellipse_word_t w;
        int            sent;
        int            nsteps;
        sent = 0;
        while (sent < target) begin
            w      = '0;
            w.chk  = CHK_PRED;
            w.cx   = $urandom_range(0, 4095);
            w.cy   = $urandom_range(0, 4095);
            if ($urandom_range(0, 99) < 85) begin
                w.act = ACT_START;
                if ($urandom_range(0, 9) == 0) begin
                    w.rx   = $urandom_range(0, 2047);
                    w.ry   = $urandom_range(0, 2047);
                    nsteps = $urandom_range(1, 8);
                end else begin
                    w.rx   = $urandom_range(0, 12);
                    w.ry   = $urandom_range(0, 12);
                    nsteps = w.rx + w.ry + $urandom_range(1, 3);
                    if ($urandom_range(0, 4) == 0)
                        nsteps = $urandom_range(1, nsteps);
                end
                pace();
                send_word(w);
                repeat (nsteps) begin
                    w.act = ACT_STEP;
                    w.cx  = $urandom_range(0, 4095);
                    w.cy  = $urandom_range(0, 4095);
                    w.rx  = $urandom_range(0, 2047);
                    w.ry  = $urandom_range(0, 2047);
                    pace();
                    send_word(w);
                end
                sent += 1 + nsteps;
            end else begin
                w.act = 1'($urandom_range(0, 1));
                w.rx  = $urandom_range(0, 2047);
                w.ry  = $urandom_range(0, 2047);
                pace();
                send_word(w);
                sent++;
            end
        end
    endtask

    // reset, directed table, then random phases under several colors
    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < NUM_DIR; i++) begin
            if (i == COLOR_ROW) begin
                drain();
                program_color(24'hFFFFFF);
            end
            pace();
            send_word(directed_words[i]);
        end
        drain();
        program_color(24'($urandom_range(1, 24'hFFFFFE)));
        run_random(PHASE_WORDS);
        drain();
        program_color(24'h000000);
        run_random(PHASE_WORDS);
        drain();
        program_color(24'($urandom));
        run_random(PHASE_WORDS);
        drain();
        if (pixel_errors == 0 && reg_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mer_pkg.sv
hw/rtl/mer_front.sv
hw/rtl/mer_core.sv
hw/rtl/mer_emit.sv
hw/rtl/midpoint_ellipse_rasterizer_top.sv
hw/rtl/mer_checker.sv
tb/tb.sv
